>>> rtl/core/sfc_pkg.sv
// ============================================================================
// sfc_pkg: shared types and constants for the sent frame capture block
// Holds the configuration and frame types, register indexes, reset values
// and the period-to-nibble conversion.
// ============================================================================
package sfc_pkg;

    // Field widths.
    localparam int TIME_W   = 32;
    localparam int CFG_W    = 10;
    localparam int NIB_W    = 4;
    localparam int SYNC_W   = 8;
    localparam int DATA_W   = 24;
    localparam int CNT_W    = 4;
    localparam int CFG_IDX_W = 2;

    // Frame layout: status nibble plus six data nibbles are held, the CRC
    // nibble arrives on the last pulse.
    localparam int HELD_DEPTH   = 7;
    localparam int HELD_IDX_W   = 3;
    localparam logic [CNT_W-1:0] LAST_PULSE = 4'd8;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NIBBLE_MIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NIBBLE_MAX  = 2'd2;

    // Register reset values.
    localparam logic [CFG_W-1:0] SYNC_PERIOD_RST = 10'd164;
    localparam logic [CFG_W-1:0] NIBBLE_MIN_RST  = 10'd36;
    localparam logic [CFG_W-1:0] NIBBLE_MAX_RST  = 10'd81;

    // Nibble conversion constants: x / 3 == (x * 171) >> 9 for 8-bit x.
    localparam logic [15:0] DIV3_MULT  = 16'd171;
    localparam logic [NIB_W-1:0] NIB_OFFSET = 4'd12;

    typedef struct packed {
        logic [CFG_W-1:0] sync_period;
        logic [CFG_W-1:0] nibble_min;
        logic [CFG_W-1:0] nibble_max;
    } sfc_cfg_t;

    typedef struct packed {
        logic [SYNC_W-1:0] sync_width;
        logic [NIB_W-1:0]  status_nibble;
        logic [DATA_W-1:0] data_nibbles;
        logic [NIB_W-1:0]  crc_nibble;
    } sfc_frame_t;

    // Nibble value from the low eight bits of a period: period / 3 - 12,
    // wrapped to four bits.
    function automatic logic [NIB_W-1:0] period_to_nibble(input logic [7:0] low);
        logic [15:0] prod;
        logic [6:0]  quot;
        prod = {8'd0, low} * DIV3_MULT;
        quot = prod[15:9];
        return quot[NIB_W-1:0] - NIB_OFFSET;
    endfunction

endpackage

>>> rtl/core/sent_frame_capture.sv
// ============================================================================
// sent_frame_capture: single-edge nibble frame decoder
// Turns falling-edge timestamps into decoded frames of sync width, status,
// six data nibbles and the CRC nibble.
// ============================================================================
// Usage:
//   The input channel (in_valid, in_ready, edge_time) carries one falling
//   edge per transfer as a 32-bit microsecond timestamp. The output channel
//   (out_valid, out_ready and the frame fields) carries one transfer per
//   completed frame: a sync pulse followed by eight in-window nibble pulses.
//   Edges that drop a frame or hunt for sync produce no output.
//   An accepted edge lands in an input register. When the output register
//   can take a result, the tracker steps on the held edge and a completed
//   frame is loaded into the output register, where it waits for out_ready.
//   Throughput is one edge per cycle while the output register can take a
//   result; tracker period compare and nibble conversion are combinational.
//   When the receiver stalls with a frame waiting, the input register holds
//   its edge and in_ready drops until the output register is taken; with
//   the output register free, edges keep flowing every cycle. Reset clears
//   the last edge time to zero, returns to sync hunting and loads the default
//   sync period and nibble window. The user must write registers through
//   cfg_wr_en, cfg_index, cfg_data while no edge is in flight; unenforced.
// ============================================================================
module sent_frame_capture (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [sfc_pkg::TIME_W-1:0]     edge_time,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [sfc_pkg::SYNC_W-1:0]     sync_width,
    output logic [sfc_pkg::NIB_W-1:0]      status_nibble,
    output logic [sfc_pkg::DATA_W-1:0]     data_nibbles,
    output logic [sfc_pkg::NIB_W-1:0]      crc_nibble,
    input  logic                           cfg_wr_en,
    input  logic [sfc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sfc_pkg::CFG_W-1:0]      cfg_data
);

    sfc_pkg::sfc_cfg_t            cfg_reg, cfg_next;
    logic                         s1_valid_reg, s1_valid_next;
    logic [sfc_pkg::TIME_W-1:0]   s1_time_reg;
    logic                         out_valid_reg, out_valid_next;
    sfc_pkg::sfc_frame_t          out_frame_reg;

    logic                         s1_advance;
    logic                         step;
    logic                         frame_done;
    sfc_pkg::sfc_frame_t          frame;

    // Configuration register writes; unused indexes are ignored.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                sfc_pkg::CFG_SYNC_PERIOD: cfg_next.sync_period = cfg_data;
                sfc_pkg::CFG_NIBBLE_MIN:  cfg_next.nibble_min  = cfg_data;
                sfc_pkg::CFG_NIBBLE_MAX:  cfg_next.nibble_max  = cfg_data;
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_period <= sfc_pkg::SYNC_PERIOD_RST;
            cfg_reg.nibble_min  <= sfc_pkg::NIBBLE_MIN_RST;
            cfg_reg.nibble_max  <= sfc_pkg::NIBBLE_MAX_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Handshake: the held edge steps whenever the output register can take
    // a result.
    assign s1_advance = !out_valid_reg || out_ready;
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign step       = s1_valid_reg && s1_advance;

    always_comb
    begin
        priority if (in_valid && in_ready)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    // Output register: load a finished frame, or drop the one taken.
    always_comb
    begin
        priority if (step && frame_done)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_time_reg <= edge_time;
        end
        if (step && frame_done)
        begin
            out_frame_reg <= frame;
        end
    end

    // Frame tracking.
    sfc_frame_track u_track (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .edge_time (s1_time_reg),
        .cfg       (cfg_reg),
        .done      (frame_done),
        .frame     (frame)
    );

    assign out_valid     = out_valid_reg;
    assign sync_width    = out_frame_reg.sync_width;
    assign status_nibble = out_frame_reg.status_nibble;
    assign data_nibbles  = out_frame_reg.data_nibbles;
    assign crc_nibble    = out_frame_reg.crc_nibble;

    // A new result only appears after the tracker finished a frame.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !$past(out_valid_reg) |-> $past(step && frame_done))
        else $error("result appeared without a completed frame");

    // Backpressure only while both registers are occupied.
    a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> s1_valid_reg && out_valid_reg)
        else $error("input stalled with a free register");

    // A held edge that cannot step keeps its timestamp.
    a_hold_edge: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_advance |=> s1_valid_reg && $stable(s1_time_reg))
        else $error("held edge lost while stalled");

endmodule

>>> rtl/core/sfc_frame_track.sv
// ============================================================================
// sfc_frame_track: edge-to-frame tracker
// Measures the period from the previous edge, hunts for the sync pulse,
// collects nibble pulses and flags a completed frame in the step of its last pulse.
// ============================================================================
module sfc_frame_track (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic [sfc_pkg::TIME_W-1:0]    edge_time,
    input  sfc_pkg::sfc_cfg_t             cfg,
    output logic                          done,
    output sfc_pkg::sfc_frame_t           frame
);

    logic [sfc_pkg::TIME_W-1:0]  last_edge_reg, last_edge_next;
    logic                        capturing_reg, capturing_next;
    logic [sfc_pkg::CNT_W-1:0]   pulse_count_reg, pulse_count_next;
    logic [sfc_pkg::SYNC_W-1:0]  held_sync_reg, held_sync_next;
    logic [sfc_pkg::NIB_W-1:0]   held_nibbles_reg [sfc_pkg::HELD_DEPTH];

    logic [sfc_pkg::TIME_W-1:0]     period;
    logic                           is_sync;
    logic                           in_window;
    logic [sfc_pkg::NIB_W-1:0]      nibble;
    logic                           held_wr;
    logic [sfc_pkg::HELD_IDX_W-1:0] held_slot;
    logic [sfc_pkg::CNT_W-1:0]      slot_full;

    // Period measurement and classification.
    assign period    = edge_time - last_edge_reg;
    assign is_sync   = period == {{(sfc_pkg::TIME_W-sfc_pkg::CFG_W){1'b0}}, cfg.sync_period};
    assign in_window = (period >= {{(sfc_pkg::TIME_W-sfc_pkg::CFG_W){1'b0}}, cfg.nibble_min})
                    && (period <= {{(sfc_pkg::TIME_W-sfc_pkg::CFG_W){1'b0}}, cfg.nibble_max});
    assign nibble    = sfc_pkg::period_to_nibble(period[7:0]);
    assign slot_full = pulse_count_reg - 4'd1;
    assign held_slot = slot_full[sfc_pkg::HELD_IDX_W-1:0];

    // Frame state machine step.
    always_comb
    begin
        last_edge_next   = last_edge_reg;
        capturing_next   = capturing_reg;
        pulse_count_next = pulse_count_reg;
        held_sync_next   = held_sync_reg;
        held_wr          = 1'b0;
        done             = 1'b0;
        if (step)
        begin
            last_edge_next = edge_time;
            priority if (!capturing_reg)
            begin
                if (is_sync)
                begin
                    capturing_next   = 1'b1;
                    pulse_count_next = 4'd1;
                    held_sync_next   = period[sfc_pkg::SYNC_W-1:0];
                end
            end
            else if (!in_window)
            begin
                capturing_next   = 1'b0;
                pulse_count_next = '0;
            end
            else if (pulse_count_reg != sfc_pkg::LAST_PULSE)
            begin
                held_wr          = 1'b1;
                pulse_count_next = pulse_count_reg + 4'd1;
            end
            else
            begin
                done             = 1'b1;
                capturing_next   = 1'b0;
                pulse_count_next = '0;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_edge_reg   <= '0;
            capturing_reg   <= 1'b0;
            pulse_count_reg <= '0;
            held_sync_reg   <= '0;
        end
        else
        begin
            last_edge_reg   <= last_edge_next;
            capturing_reg   <= capturing_next;
            pulse_count_reg <= pulse_count_next;
            held_sync_reg   <= held_sync_next;
        end
    end

    // Held nibbles are written before they are read within a frame.
    always_ff @(posedge clk)
    begin
        if (held_wr)
        begin
            held_nibbles_reg[held_slot] <= nibble;
        end
    end

    // Completed frame, first data nibble in the top bits.
    assign frame.sync_width    = held_sync_reg;
    assign frame.status_nibble = held_nibbles_reg[0];
    assign frame.data_nibbles  = {held_nibbles_reg[1], held_nibbles_reg[2],
                                  held_nibbles_reg[3], held_nibbles_reg[4],
                                  held_nibbles_reg[5], held_nibbles_reg[6]};
    assign frame.crc_nibble    = nibble;

    // The pulse count never passes the last pulse of a frame.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        pulse_count_reg <= sfc_pkg::LAST_PULSE)
        else $error("pulse count out of range");

    // While hunting for sync, no pulses are counted.
    a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
        !capturing_reg |-> pulse_count_reg == '0)
        else $error("pulse count nonzero while idle");

    // A frame completes only on its last pulse, and tracking then goes idle.
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> capturing_reg && pulse_count_reg == sfc_pkg::LAST_PULSE
                 ##1 !capturing_reg)
        else $error("frame completed at the wrong pulse");

endmodule
